/* rtl/core/periodic_sphere_mask_point_top_assert.svh */
// assertion macros used by the checker file
`ifndef PERIODIC_SPHERE_MASK_POINT_TOP_ASSERT_SVH
`define PERIODIC_SPHERE_MASK_POINT_TOP_ASSERT_SVH

// clocked assertion, switched off while reset is low
`define PSMP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds while reset is low
`define PSMP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/psmp_pkg.sv */
package psmp_pkg;

  // lattice size in fine grid points per axis
  localparam int GRID_X = 128;
  localparam int GRID_Y = 128;
  localparam int GRID_Z = 128;
  localparam int GRID_XY_MAX = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
  localparam int GRID_MAX = (GRID_XY_MAX > GRID_Z) ? GRID_XY_MAX : GRID_Z;

  // field widths
  localparam int IDX_W  = 7;
  localparam int ORG_W  = 8;
  localparam int CTR_W  = 32;
  localparam int SPC_W  = 24;
  localparam int LVL_W  = 2;
  localparam int CUT_W  = 31;
  localparam int MODE_W = 2;
  localparam int DIST_W = 63;

  // derived datapath widths
  localparam int MAX_SHIFT = (1 << LVL_W) - 1;
  localparam int K_W   = IDX_W + MAX_SHIFT + 2;
  localparam int P_W   = SPC_W + 1 + K_W;
  localparam int D_W   = ((P_W > CTR_W) ? P_W : CTR_W) + 1;
  localparam int LEN_W = SPC_W + $clog2(GRID_MAX + 1);
  localparam int IMG_W = ((D_W > LEN_W + 1) ? D_W : LEN_W + 1) + 1;
  localparam int SQ_IN_W = 32;
  localparam int R2_W  = 2 * CUT_W;

  // largest magnitude whose square stays below the 63-bit ceiling
  localparam logic [IMG_W-1:0]  ROOT_SAT = IMG_W'(64'd3037000499);
  localparam logic [DIST_W-1:0] DIST_SAT = '1;

  // back pipeline depth, last stage is the output register
  localparam int NSTG = 6;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // register file
  localparam int NUM_REGS = 6;
  localparam int APB_DW = 32;
  localparam int APB_AW = $clog2(NUM_REGS) + 2;
  localparam int RIDX_W = APB_AW - 2;

  localparam logic [SPC_W-1:0] SPC_RST = SPC_W'(13107);
  localparam logic [LVL_W-1:0] LVL_RST = '0;
  localparam logic [CUT_W-1:0] CUT_RST = CUT_W'(655360);

  typedef enum logic [RIDX_W-1:0] {
    REG_SPACING_X     = 3'd0,
    REG_SPACING_Y     = 3'd1,
    REG_SPACING_Z     = 3'd2,
    REG_GRID_LEVEL    = 3'd3,
    REG_CUTOFF_RADIUS = 3'd4,
    REG_BOUNDARY_MODE = 3'd5
  } psmp_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_FULL  = 2'd0,
    MODE_ZONLY = 2'd1,
    MODE_NONE  = 2'd2
  } psmp_mode_e;

  localparam logic [MODE_W-1:0] MODE_RST = MODE_FULL;

  typedef struct packed {
    logic [SPC_W-1:0]  spc_x;
    logic [SPC_W-1:0]  spc_y;
    logic [SPC_W-1:0]  spc_z;
    logic [LVL_W-1:0]  level;
    logic [CUT_W-1:0]  cutoff;
    logic [MODE_W-1:0] mode;
  } psmp_cfg_t;

  // one classified grid point as held in the queue
  typedef struct packed {
    logic signed [K_W-1:0]   k_x;
    logic signed [K_W-1:0]   k_y;
    logic signed [K_W-1:0]   k_z;
    logic signed [CTR_W-1:0] c_x;
    logic signed [CTR_W-1:0] c_y;
    logic signed [CTR_W-1:0] c_z;
    logic                    per_x;
    logic                    per_y;
    logic                    per_z;
  } psmp_item_t;

endpackage

/* rtl/core/periodic_sphere_mask_point_top.sv */
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------
// input    | in_valid_i / in_stall_o    | point_i*, box_origin_*, center_*
// output   | out_valid_o / out_stall_i  | inside_res_o, min_distance_squared_o
// config   | psel penable pwrite pready | paddr, pwdata, prdata
//
// one beat per cycle sustained while the output beat is not held
// the result path is the six-stage back pipeline behind a two-entry queue
// reset is asynchronous and active low, registers return to their defaults
// a held output beat freezes the back pipeline; the queue then fills and stalls input
module periodic_sphere_mask_point_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [psmp_pkg::IDX_W-1:0]          point_ix_i,
  input  logic [psmp_pkg::IDX_W-1:0]          point_iy_i,
  input  logic [psmp_pkg::IDX_W-1:0]          point_iz_i,
  input  logic signed [psmp_pkg::ORG_W-1:0]   box_origin_x_i,
  input  logic signed [psmp_pkg::ORG_W-1:0]   box_origin_y_i,
  input  logic signed [psmp_pkg::ORG_W-1:0]   box_origin_z_i,
  input  logic signed [psmp_pkg::CTR_W-1:0]   center_x_i,
  input  logic signed [psmp_pkg::CTR_W-1:0]   center_y_i,
  input  logic signed [psmp_pkg::CTR_W-1:0]   center_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                inside_res_o,
  output logic [psmp_pkg::DIST_W-1:0]         min_distance_squared_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [psmp_pkg::APB_AW-1:0]         paddr,
  input  logic [psmp_pkg::APB_DW-1:0]         pwdata,
  output logic [psmp_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import psmp_pkg::*;

  logic [SPC_W-1:0]  spc_x_q, spc_y_q, spc_z_q;
  logic [LVL_W-1:0]  level_q;
  logic [CUT_W-1:0]  cutoff_q;
  logic [MODE_W-1:0] mode_q;
  logic              wr_en;
  logic [RIDX_W-1:0] ridx;
  psmp_cfg_t         cfg;

  logic              q_full;
  logic              q_push;
  psmp_item_t        q_in;
  logic              q_valid;
  logic              q_pop;
  psmp_item_t        q_head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign ridx   = paddr[APB_AW-1:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_x_q  <= SPC_RST;
      spc_y_q  <= SPC_RST;
      spc_z_q  <= SPC_RST;
      level_q  <= LVL_RST;
      cutoff_q <= CUT_RST;
      mode_q   <= MODE_RST;
    end else if (wr_en) begin
      unique case (ridx)
        REG_SPACING_X:     spc_x_q  <= pwdata[SPC_W-1:0];
        REG_SPACING_Y:     spc_y_q  <= pwdata[SPC_W-1:0];
        REG_SPACING_Z:     spc_z_q  <= pwdata[SPC_W-1:0];
        REG_GRID_LEVEL:    level_q  <= pwdata[LVL_W-1:0];
        REG_CUTOFF_RADIUS: cutoff_q <= pwdata[CUT_W-1:0];
        REG_BOUNDARY_MODE: mode_q   <= pwdata[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (ridx)
      REG_SPACING_X:     prdata = APB_DW'(spc_x_q);
      REG_SPACING_Y:     prdata = APB_DW'(spc_y_q);
      REG_SPACING_Z:     prdata = APB_DW'(spc_z_q);
      REG_GRID_LEVEL:    prdata = APB_DW'(level_q);
      REG_CUTOFF_RADIUS: prdata = APB_DW'(cutoff_q);
      REG_BOUNDARY_MODE: prdata = APB_DW'(mode_q);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    cfg.spc_x  = spc_x_q;
    cfg.spc_y  = spc_y_q;
    cfg.spc_z  = spc_z_q;
    cfg.level  = level_q;
    cfg.cutoff = cutoff_q;
    cfg.mode   = mode_q;
  end

  psmp_front u_front (
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .point_ix_i     (point_ix_i),
    .point_iy_i     (point_iy_i),
    .point_iz_i     (point_iz_i),
    .box_origin_x_i (box_origin_x_i),
    .box_origin_y_i (box_origin_y_i),
    .box_origin_z_i (box_origin_z_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .center_z_i     (center_z_i),
    .full_i         (q_full),
    .push_o         (q_push),
    .item_o         (q_in)
  );

  psmp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_head)
  );

  psmp_back u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_i                  (cfg),
    .q_valid_i              (q_valid),
    .q_item_i               (q_head),
    .q_pop_o                (q_pop),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .inside_res_o           (inside_res_o),
    .min_distance_squared_o (min_distance_squared_o)
  );

endmodule

/* rtl/core/psmp_queue.sv */
module psmp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  psmp_pkg::psmp_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output psmp_pkg::psmp_item_t item_o
);
  import psmp_pkg::*;

  psmp_item_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/core/psmp_front.sv */
module psmp_front (
  input  psmp_pkg::psmp_cfg_t         cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [psmp_pkg::IDX_W-1:0]  point_ix_i,
  input  logic [psmp_pkg::IDX_W-1:0]  point_iy_i,
  input  logic [psmp_pkg::IDX_W-1:0]  point_iz_i,
  input  logic signed [psmp_pkg::ORG_W-1:0] box_origin_x_i,
  input  logic signed [psmp_pkg::ORG_W-1:0] box_origin_y_i,
  input  logic signed [psmp_pkg::ORG_W-1:0] box_origin_z_i,
  input  logic signed [psmp_pkg::CTR_W-1:0] center_x_i,
  input  logic signed [psmp_pkg::CTR_W-1:0] center_y_i,
  input  logic signed [psmp_pkg::CTR_W-1:0] center_z_i,
  input  logic                        full_i,
  output logic                        push_o,
  output psmp_pkg::psmp_item_t        item_o
);
  import psmp_pkg::*;

  // fine grid offset of the point: origin plus index scaled by the level
  function automatic logic signed [K_W-1:0] fine_offset(
    logic [IDX_W-1:0]        idx,
    logic signed [ORG_W-1:0] org,
    logic [LVL_W-1:0]        lv
  );
    return K_W'(org) + (K_W'(idx) << lv);
  endfunction

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // classify the beat: fine offsets and which axes take images
  always_comb begin
    item_o.k_x   = fine_offset(point_ix_i, box_origin_x_i, cfg_i.level);
    item_o.k_y   = fine_offset(point_iy_i, box_origin_y_i, cfg_i.level);
    item_o.k_z   = fine_offset(point_iz_i, box_origin_z_i, cfg_i.level);
    item_o.c_x   = center_x_i;
    item_o.c_y   = center_y_i;
    item_o.c_z   = center_z_i;
    item_o.per_x = 1'b0;
    item_o.per_y = 1'b0;
    item_o.per_z = 1'b0;
    case (cfg_i.mode)
      MODE_FULL: begin
        item_o.per_x = 1'b1;
        item_o.per_y = 1'b1;
        item_o.per_z = 1'b1;
      end
      MODE_ZONLY: begin
        item_o.per_z = 1'b1;
      end
      MODE_NONE: begin
        item_o.per_z = 1'b0;
      end
      // unused mode code acts as no images
      default: begin
        item_o.per_z = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/psmp_back.sv */
module psmp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psmp_pkg::psmp_cfg_t           cfg_i,
  input  logic                          q_valid_i,
  input  psmp_pkg::psmp_item_t          q_item_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          inside_res_o,
  output logic [psmp_pkg::DIST_W-1:0]   min_distance_squared_o
);
  import psmp_pkg::*;

  function automatic logic [IMG_W-1:0] mag(logic signed [IMG_W-1:0] v);
    return v[IMG_W-1] ? -v : v;
  endfunction

  function automatic logic [DIST_W-1:0] add_sat(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_SAT : s[DIST_W-1:0];
  endfunction

  logic                    adv;
  logic [NSTG-1:0]         vld_q, vld_d;

  logic [SPC_W-1:0]        spc [3];
  logic signed [K_W-1:0]   k_in [3];
  logic signed [CTR_W-1:0] c_in [3];
  logic                    per_in [3];

  logic [LEN_W-1:0]        len_q [3];
  logic [R2_W-1:0]         r2_q;

  logic signed [P_W-1:0]   p_q [3];
  logic signed [CTR_W-1:0] c1_q [3];
  logic                    per1_q [3];

  logic signed [IMG_W-1:0] d_d [3];
  logic signed [IMG_W-1:0] dd_q [3];
  logic signed [IMG_W-1:0] dm_q [3];
  logic signed [IMG_W-1:0] dp_q [3];

  logic [IMG_W-1:0]        m0 [3];
  logic [IMG_W-1:0]        m1 [3];
  logic [IMG_W-1:0]        m2 [3];
  logic [IMG_W-1:0]        m01 [3];
  logic [IMG_W-1:0]        mag_q [3];

  logic [2*SQ_IN_W-1:0]    prod [3];
  logic [DIST_W-1:0]       sq_q [3];

  logic [DIST_W-1:0]       sum_xy_q;
  logic [DIST_W-1:0]       sqz_q;

  logic [DIST_W-1:0]       dist_d;
  logic [DIST_W-1:0]       dist_q;
  logic                    inside_q;

  // whole pipeline moves unless the output beat is held
  assign adv     = !(vld_q[NSTG-1] && out_stall_i);
  assign q_pop_o = adv && q_valid_i;

  assign out_valid_o            = vld_q[NSTG-1];
  assign inside_res_o           = inside_q;
  assign min_distance_squared_o = dist_q;

  // per-axis views of the queue head and config
  always_comb begin
    spc[0]    = cfg_i.spc_x;
    spc[1]    = cfg_i.spc_y;
    spc[2]    = cfg_i.spc_z;
    k_in[0]   = q_item_i.k_x;
    k_in[1]   = q_item_i.k_y;
    k_in[2]   = q_item_i.k_z;
    c_in[0]   = q_item_i.c_x;
    c_in[1]   = q_item_i.c_y;
    c_in[2]   = q_item_i.c_z;
    per_in[0] = q_item_i.per_x;
    per_in[1] = q_item_i.per_y;
    per_in[2] = q_item_i.per_z;
  end

  // stage valid bits
  always_comb begin
    vld_d = vld_q;
    if (adv) begin
      vld_d = {vld_q[NSTG-2:0], q_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // lattice lengths and squared cutoff, static between config writes
  always_ff @(posedge clk_i) begin
    len_q[0] <= LEN_W'(cfg_i.spc_x) * LEN_W'(GRID_X);
    len_q[1] <= LEN_W'(cfg_i.spc_y) * LEN_W'(GRID_Y);
    len_q[2] <= LEN_W'(cfg_i.spc_z) * LEN_W'(GRID_Z);
    r2_q     <= R2_W'(cfg_i.cutoff) * R2_W'(cfg_i.cutoff);
  end

  // direct difference and image candidates, minimum magnitude, square
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d_d[a]  = IMG_W'(p_q[a]) - IMG_W'(c1_q[a]);
      m0[a]   = mag(dd_q[a]);
      m1[a]   = mag(dm_q[a]);
      m2[a]   = mag(dp_q[a]);
      m01[a]  = (m1[a] < m0[a]) ? m1[a] : m0[a];
      prod[a] = mag_q[a][SQ_IN_W-1:0] * mag_q[a][SQ_IN_W-1:0];
    end
    dist_d = add_sat(sum_xy_q, sqz_q);
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        // position along the axis
        p_q[a]    <= $signed({1'b0, spc[a]}) * k_in[a];
        c1_q[a]   <= c_in[a];
        per1_q[a] <= per_in[a];
        // difference to the center and its two neighbor images
        dd_q[a]   <= d_d[a];
        dm_q[a]   <= per1_q[a] ? d_d[a] - IMG_W'(len_q[a]) : d_d[a];
        dp_q[a]   <= per1_q[a] ? d_d[a] + IMG_W'(len_q[a]) : d_d[a];
        // nearest image
        mag_q[a]  <= (m2[a] < m01[a]) ? m2[a] : m01[a];
        // saturating square
        sq_q[a]   <= (mag_q[a] > ROOT_SAT) ? DIST_SAT : prod[a][DIST_W-1:0];
      end
      sum_xy_q <= add_sat(sq_q[0], sq_q[1]);
      sqz_q    <= sq_q[2];
      dist_q   <= dist_d;
      inside_q <= (dist_d <= DIST_W'(r2_q));
    end
  end

endmodule

/* rtl/core/psmp_checker.sv */
`include "periodic_sphere_mask_point_top_assert.svh"

module psmp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        inside_res_o,
  input logic [psmp_pkg::DIST_W-1:0] min_distance_squared_o
);
  import psmp_pkg::*;

  // a held result beat keeps its payload
  `PSMP_ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(min_distance_squared_o) && $stable(inside_res_o), "output beat changed while stalled")

  // an inside point lies within rcut squared, which stays below 2^62
  `PSMP_ASSERT_CLK(a_inside_range, clk_i, rst_ni, out_valid_o && inside_res_o |-> !min_distance_squared_o[DIST_W-1], "inside flag with distance beyond any cutoff")

  // no result beat follows a clock edge that sees reset low
  `PSMP_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o, "output valid during reset")

endmodule

bind periodic_sphere_mask_point_top psmp_checker u_psmp_checker (.*);
